### hdl/calh_pkg.sv
`timescale 1ns / 1ps
// calh_pkg: shared types and constants for the calibration histogram
// no dependencies; used by calh_div and calibration_histogram

package calh_pkg;

    // fixed field widths
    localparam int CRED_BITS    = 7;
    localparam int OC_BITS      = 2;
    localparam int PCT_BITS     = 7;
    localparam int OUT_CNT_BITS = 16;

    // percent scale and fold point
    localparam logic [CRED_BITS-1:0] PCT_SCALE  = 7'd100;
    localparam logic [CRED_BITS-1:0] FOLD_POINT = 7'd50;

    // outcome codes
    localparam logic [OC_BITS-1:0] OC_FALSE = 2'd0;
    localparam logic [OC_BITS-1:0] OC_TRUE  = 2'd1;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_MUL,
        ST_DIV
    } t_state;

endpackage

### hdl/calibration_histogram.sv
`timescale 1ns / 1ps
// calibration_histogram: top level, fold decode, bin update sequencer, outputs
// depends on calh_pkg, calh_mem and calh_div

// One prediction is taken when start is high and busy is low, and its result
// appears on the o_ ports for exactly one cycle with o_valid high; the receiver
// cannot hold it off. An out-of-range credence returns its flagged result in the
// cycle after acceptance and busy never rises. A valid credence keeps busy high
// through these steps: the bin is read at the accepting edge, then updated and
// written back (ST_UPD), the true count is scaled by 100 and loaded into the
// bit-serial divider (ST_MUL), the divider forms the percentage (ST_DIV), and
// the result is registered as busy falls; o_valid is then high while the block
// is idle, before the next acceptance. The bin memory needs no clearing pass
// after reset. The user must keep fold_mode written through i_fold_we /
// i_fold_wdata only while the block is idle; the block does not enforce it.

module calibration_histogram #(
    parameter int NUM_BINS   = 100,
    parameter int COUNT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [calh_pkg::CRED_BITS-1:0]       i_credence,
    input  logic [calh_pkg::OC_BITS-1:0]         i_outcome,
    input  logic                                 i_fold_we,
    input  logic                                 i_fold_wdata,
    output logic                                 o_valid,
    output logic [calh_pkg::CRED_BITS-1:0]       o_bin_index,
    output logic [calh_pkg::OUT_CNT_BITS-1:0]    o_true_count,
    output logic [calh_pkg::OUT_CNT_BITS-1:0]    o_false_count,
    output logic [calh_pkg::PCT_BITS-1:0]        o_percent_true,
    output logic                                 o_percent_valid,
    output logic                                 o_bad_credence,
    output logic [calh_pkg::OUT_CNT_BITS-1:0]    o_total_recorded
);

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int NW = COUNT_BITS + calh_pkg::PCT_BITS;
    localparam int DW = COUNT_BITS + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    calh_pkg::t_state r_state, n_state;

    logic                              r_fold_mode;
    logic [calh_pkg::CRED_BITS-1:0]    r_bin;
    logic                              r_swap;
    logic                              r_outcome_true;
    logic                              r_do_count;
    logic [COUNT_BITS-1:0]             r_t;
    logic [COUNT_BITS-1:0]             r_f;
    logic [COUNT_BITS-1:0]             r_total;

    logic                              r_valid;
    logic [calh_pkg::CRED_BITS-1:0]    r_bin_index;
    logic [calh_pkg::OUT_CNT_BITS-1:0] r_true_count;
    logic [calh_pkg::OUT_CNT_BITS-1:0] r_false_count;
    logic [calh_pkg::PCT_BITS-1:0]     r_percent_true;
    logic                              r_percent_valid;
    logic                              r_bad_credence;

    logic [calh_pkg::CRED_BITS-1:0]    bin_c;
    logic                              ok_c;
    logic                              swap_c;
    logic                              accept;
    logic [2*COUNT_BITS-1:0]           rd_data;
    logic [COUNT_BITS-1:0]             cur_t;
    logic [COUNT_BITS-1:0]             cur_f;
    logic [COUNT_BITS-1:0]             new_t;
    logic [COUNT_BITS-1:0]             new_f;
    logic                              is_true;
    logic                              wr_en;
    logic                              div_start;
    logic                              div_done;
    logic [calh_pkg::PCT_BITS-1:0]     div_quot;
    logic [NW-1:0]                     num;
    logic [DW-1:0]                     den;

    assign accept = start && (r_state == calh_pkg::ST_IDLE);
    assign busy   = (r_state != calh_pkg::ST_IDLE);

    // credence to bin, with folding above the midpoint
    always_comb begin
        bin_c  = i_credence;
        ok_c   = 1'b1;
        swap_c = 1'b0;
        if (r_fold_mode) begin
            if (i_credence >= 7'd1 && i_credence <= calh_pkg::FOLD_POINT) begin
                bin_c = i_credence;
            end else if (i_credence > calh_pkg::FOLD_POINT &&
                         i_credence < calh_pkg::PCT_SCALE) begin
                bin_c  = calh_pkg::PCT_SCALE - i_credence;
                swap_c = 1'b1;
            end else begin
                bin_c = '0;
                ok_c  = 1'b0;
            end
        end
        if (32'(bin_c) >= NUM_BINS) begin
            ok_c = 1'b0;
        end
    end

    // fold mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_mode <= 1'b0;
        end else if (i_fold_we) begin
            r_fold_mode <= i_fold_wdata;
        end
    end

    // bin count memory, true count in the upper half
    calh_mem #(
        .DEPTH (NUM_BINS),
        .WIDTH (2 * COUNT_BITS),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && ok_c),
        .i_rd_addr (AW'(bin_c)),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_bin)),
        .i_wr_data ({new_t, new_f}),
        .o_rd_data (rd_data)
    );

    // saturating bin update
    always_comb begin
        cur_t   = rd_data[2*COUNT_BITS-1:COUNT_BITS];
        cur_f   = rd_data[COUNT_BITS-1:0];
        is_true = r_outcome_true ^ r_swap;
        new_t   = cur_t;
        new_f   = cur_f;
        if (r_do_count) begin
            if (is_true) begin
                new_t = (cur_t == COUNT_MAX) ? cur_t : cur_t + 1'b1;
            end else begin
                new_f = (cur_f == COUNT_MAX) ? cur_f : cur_f + 1'b1;
            end
        end
        wr_en = (r_state == calh_pkg::ST_UPD) && r_do_count;
    end

    // percentage divider operands
    always_comb begin
        num       = NW'(r_t) * NW'(calh_pkg::PCT_SCALE);
        den       = DW'(r_t) + DW'(r_f);
        div_start = (r_state == calh_pkg::ST_MUL);
    end

    calh_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= calh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            calh_pkg::ST_IDLE: begin
                if (accept && ok_c) begin
                    n_state = calh_pkg::ST_UPD;
                end
            end
            calh_pkg::ST_UPD: n_state = calh_pkg::ST_MUL;
            calh_pkg::ST_MUL: n_state = calh_pkg::ST_DIV;
            calh_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = calh_pkg::ST_IDLE;
                end
            end
            default: n_state = calh_pkg::ST_IDLE;
        endcase
    end

    // transaction and count registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin          <= bin_c;
            r_swap         <= swap_c;
            r_outcome_true <= (i_outcome == calh_pkg::OC_TRUE);
            r_do_count     <= (i_outcome == calh_pkg::OC_TRUE) ||
                              (i_outcome == calh_pkg::OC_FALSE);
        end
        if (r_state == calh_pkg::ST_UPD) begin
            r_t <= new_t;
            r_f <= new_f;
        end
    end

    // running total of counted outcomes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (wr_en && r_total != COUNT_MAX) begin
            r_total <= r_total + 1'b1;
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (accept && !ok_c) || (r_state == calh_pkg::ST_DIV && div_done);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (accept && !ok_c) begin
            r_bin_index     <= '0;
            r_true_count    <= '0;
            r_false_count   <= '0;
            r_percent_true  <= '0;
            r_percent_valid <= 1'b0;
            r_bad_credence  <= 1'b1;
        end else if (r_state == calh_pkg::ST_DIV && div_done) begin
            r_bin_index     <= r_bin;
            r_true_count    <= calh_pkg::OUT_CNT_BITS'(r_t);
            r_false_count   <= calh_pkg::OUT_CNT_BITS'(r_f);
            r_percent_valid <= (den != '0);
            r_percent_true  <= (den != '0) ? div_quot : '0;
            r_bad_credence  <= 1'b0;
        end
    end

    assign o_valid          = r_valid;
    assign o_bin_index      = r_bin_index;
    assign o_true_count     = r_true_count;
    assign o_false_count    = r_false_count;
    assign o_percent_true   = r_percent_true;
    assign o_percent_valid  = r_percent_valid;
    assign o_bad_credence   = r_bad_credence;
    assign o_total_recorded = calh_pkg::OUT_CNT_BITS'(r_total);

endmodule

### hdl/calh_mem.sv
`timescale 1ns / 1ps
// calh_mem: bin count memory, one write and one read port, registered read
// per-entry valid bits make unwritten bins read as zero after reset

module calh_mem #(
    parameter int DEPTH = 100,
    parameter int WIDTH = 32,
    parameter int AW    = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;

    // storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    // a never-written entry reads as zero
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

### hdl/calh_div.sv
`timescale 1ns / 1ps
// calh_div: restoring divider, one quotient bit per cycle, 7-bit quotient
// depends on calh_pkg for the quotient width

module calh_div #(
    parameter int NW = 23,
    parameter int DW = 17
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NW-1:0]                i_num,
    input  logic [DW-1:0]                i_den,
    output logic                         o_done,
    output logic [calh_pkg::PCT_BITS-1:0] o_quot
);

    localparam int SW = $clog2(calh_pkg::PCT_BITS);

    logic [NW-1:0]                 r_rem;
    logic [DW-1:0]                 r_den;
    logic [calh_pkg::PCT_BITS-1:0] r_quot;
    logic [SW-1:0]                 r_step;
    logic                          r_busy;
    logic                          r_done;
    logic [NW-1:0]                 shifted;
    logic                          fits;

    // trial subtrahend for the current quotient bit
    always_comb begin
        shifted = NW'(r_den) << r_step;
        fits    = (r_rem >= shifted);
    end

    // operand and quotient registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy && fits) begin
            r_rem          <= r_rem - shifted;
            r_quot[r_step] <= 1'b1;
        end
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= SW'(calh_pkg::PCT_BITS - 1);
            end else if (r_busy) begin
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule
